[src/cki_pkg.sv]
// ============================================================================
// cki_pkg
// Shared types and constants for the cyclic keyframe interpolator.
// ============================================================================
package cki_pkg;
    localparam int OP_W     = 2;
    localparam int KIDX_W   = 4;
    localparam int CH_W     = 5;
    localparam int VAL_W    = 32;
    localparam int TIN_W    = 24;
    localparam int KT_W     = 21;
    localparam int CFG_W    = 5;
    localparam int FRAC_W   = 16;
    localparam logic [KT_W-1:0] DAY_Q16 = KT_W'(1572864);

    typedef enum logic [OP_W-1:0] {
        OP_WR_TIME  = 2'd0,
        OP_WR_VALUE = 2'd1,
        OP_QUERY    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [KIDX_W-1:0] key_index;
        logic [CH_W-1:0]   channel_index;
        logic signed [VAL_W-1:0] value;
        logic signed [TIN_W-1:0] time_hours;
    } t_req;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_rsp;

    // controller -> datapath commands
    typedef struct packed {
        logic load_req;    // capture request, load time
        logic red_step;    // one reduction step
        logic seg_start;   // read key times of segment (address phase)
        logic seg_eval;    // evaluate segment
        logic div_start;
        logic div_step;
        logic ch_rd;       // issue reads for channel
        logic ch_mul;      // multiply stage
        logic ch_out;      // produce result
        logic wr_time;
        logic wr_value;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic red_done;
        logic seg_hit;
        logic seg_last;
        logic div_done;
        logic ch_last;
    } t_sts;
endpackage

[src/cki_if.sv]
// ============================================================================
// cki_stream_if
// Valid/ready channel carrying one payload.
// ============================================================================
interface cki_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/cki_ram.sv]
// ============================================================================
// cki_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cki_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[src/cki_datapath.sv]
// ============================================================================
// cki_datapath
// Key storage, time reduction, segment test, divider and channel blend.
// ============================================================================
module cki_datapath #(
    parameter int MAX_KEYS = 16,
    parameter int CHANNELS = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cki_pkg::t_req        i_req,
    input  logic [4:0]           i_cfg,
    input  cki_pkg::t_cmd        i_cmd,
    output cki_pkg::t_sts        o_sts,
    output cki_pkg::t_rsp        o_rsp
);
    import cki_pkg::*;

    localparam int KA_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CA_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VD   = MAX_KEYS * CHANNELS;
    localparam int VA_W = (VD > 1) ? $clog2(VD) : 1;
    localparam int CNT_W = KA_W + 1;

    // request capture and time reduction (add or subtract one day, 25 bit signed)
    t_req r_req;
    logic signed [TIN_W:0] r_t;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
            r_t   <= (TIN_W+1)'(i_req.time_hours);
        end else if (i_cmd.red_step) begin
            if (r_t < 0) r_t <= r_t + (TIN_W+1)'(DAY_Q16);
            else         r_t <= r_t - (TIN_W+1)'(DAY_Q16);
        end
    end
    assign o_sts.red_done = (r_t >= 0) && (r_t < (TIN_W+1)'(DAY_Q16));
    logic [KT_W-1:0] tq;
    assign tq = r_t[KT_W-1:0];

    // active key count, clamped
    logic [CNT_W-1:0] n_keys;
    always_comb begin
        if (i_cfg == '0) n_keys = CNT_W'(1);
        else if (32'(i_cfg) > MAX_KEYS) n_keys = CNT_W'(MAX_KEYS);
        else n_keys = CNT_W'(i_cfg);
    end

    // key time store: flop array read at two signal addresses -> two RAMs
    logic [KA_W-1:0] r_seg;
    logic [KA_W-1:0] seg_nxt;
    assign seg_nxt = (CNT_W'(r_seg) + 1'b1 >= n_keys) ? '0 : KA_W'(r_seg + 1'b1);
    logic [KT_W-1:0] ts, te;
    logic kt_we;
    logic [KA_W-1:0] kt_wa;
    assign kt_we = i_cmd.wr_time && (32'(r_req.key_index) < MAX_KEYS);
    assign kt_wa = KA_W'(r_req.key_index);

    cki_ram #(.WIDTH(KT_W), .DEPTH(MAX_KEYS)) u_kt_a (
        .i_clk(i_clk), .i_we(kt_we), .i_waddr(kt_wa), .i_wdata(tq),
        .i_raddr(r_seg), .o_rdata(ts));
    cki_ram #(.WIDTH(KT_W), .DEPTH(MAX_KEYS)) u_kt_b (
        .i_clk(i_clk), .i_we(kt_we), .i_waddr(kt_wa), .i_wdata(tq),
        .i_raddr(seg_nxt), .o_rdata(te));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_seg <= '0;
        else if (i_cmd.seg_eval && !o_sts.seg_hit && !o_sts.seg_last)
            r_seg <= seg_nxt;
    end

    // segment test
    logic [KT_W:0] s_w, e_w, adj;
    always_comb begin
        s_w = {1'b0, ts};
        e_w = (te < ts) ? ({1'b0, te} + {1'b0, DAY_Q16}) : {1'b0, te};
        adj = (tq < ts) ? ({1'b0, tq} + {1'b0, DAY_Q16}) : {1'b0, tq};
    end
    assign o_sts.seg_hit  = (adj >= s_w) && (adj < e_w);
    assign o_sts.seg_last = (CNT_W'(r_seg) + 1'b1 >= n_keys);

    // restoring divider: ((adj-s)<<16)/(e-s), quotient < 2^16
    logic [KT_W:0]   r_den, r_rem;
    logic [FRAC_W-1:0] r_q;
    logic [4:0]      r_dcnt;
    logic [KA_W-1:0] r_cur, r_nxt;
    logic [KT_W+1:0] trial;
    assign trial = {r_rem, 1'b0} - {1'b0, r_den};
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_eval) begin
            if (o_sts.seg_hit) begin
                r_cur <= r_seg;
                r_nxt <= seg_nxt;
                r_rem <= adj - s_w;
                r_den <= e_w - s_w;
            end else begin
                r_cur <= KA_W'(n_keys - 1'b1);
                r_nxt <= KA_W'(n_keys - 1'b1);
                r_rem <= '0;
                r_den <= (KT_W+1)'(1);
            end
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[KT_W+1]) begin
                r_rem <= trial[KT_W:0];
                r_q   <= {r_q[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[KT_W-1:0], 1'b0};
                r_q   <= {r_q[FRAC_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end
    end
    assign o_sts.div_done = (r_dcnt == 5'(FRAC_W));

    // key value store: two reads per channel -> two RAMs
    logic [CA_W-1:0] r_ch;
    logic [VA_W-1:0] va_a, va_b, vw;
    logic [VAL_W-1:0] va, vb;
    logic kv_we;
    assign vw = VA_W'(32'(r_req.key_index) * CHANNELS + 32'(r_req.channel_index));
    assign kv_we = i_cmd.wr_value && (32'(r_req.key_index) < MAX_KEYS)
                   && (32'(r_req.channel_index) < CHANNELS);
    assign va_a = VA_W'(32'(r_cur) * CHANNELS + 32'(r_ch));
    assign va_b = VA_W'(32'(r_nxt) * CHANNELS + 32'(r_ch));

    cki_ram #(.WIDTH(VAL_W), .DEPTH(VD)) u_kv_a (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(vw), .i_wdata(r_req.value),
        .i_raddr(va_a), .o_rdata(va));
    cki_ram #(.WIDTH(VAL_W), .DEPTH(VD)) u_kv_b (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(vw), .i_wdata(r_req.value),
        .i_raddr(va_b), .o_rdata(vb));

    // blend: a + floor((b-a)*f / 2^16)
    logic signed [VAL_W:0] r_a, r_diff;
    logic signed [VAL_W+FRAC_W+1:0] r_prod;
    logic [CA_W-1:0] r_ch_m, r_ch_o;
    logic signed [VAL_W+FRAC_W+1:0] sum;
    assign sum = r_prod + ((VAL_W+FRAC_W+2)'(r_a) <<< FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_ch <= '0;
        else if (i_cmd.ch_rd) r_ch <= r_ch + 1'b1;
        if (i_cmd.ch_mul) begin
            r_a    <= (VAL_W+1)'($signed(va));
            r_prod <= ((VAL_W+1)'($signed(vb)) - (VAL_W+1)'($signed(va)))
                      * $signed({1'b0, r_q});
            r_ch_m <= r_ch - 1'b1;
        end
        if (i_cmd.ch_out) begin
            o_rsp.out_channel <= CH_W'(r_ch_m);
            o_rsp.out_value   <= sum[VAL_W+FRAC_W-1:FRAC_W];
            o_rsp.last        <= (32'(r_ch_m) == CHANNELS - 1);
            r_ch_o            <= r_ch_m;
        end
    end
    assign r_diff = '0;
    assign o_sts.ch_last = (32'(r_ch) >= CHANNELS - 1);

    logic unused;
    assign unused = ^{r_diff, r_ch_o, r_req.operation, i_rst_n};
endmodule

[src/cki_ctrl.sv]
// ============================================================================
// cki_ctrl
// Request sequencer: reduce time, then write, or for a query scan, divide and stream channel results.
// ============================================================================
module cki_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_op,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output cki_pkg::t_cmd  o_cmd,
    input  cki_pkg::t_sts  i_sts
);
    import cki_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_SEG_RD, S_SEG, S_DIV, S_CH_RD, S_CH_MUL, S_CH_OUT, S_HOLD
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   r_last_ch;
    t_op    r_op;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_req  = (r_state == S_IDLE) && i_valid;
        o_cmd.red_step  = (r_state == S_RED) && !i_sts.red_done;
        o_cmd.wr_time   = (r_state == S_RED) && i_sts.red_done && (r_op == OP_WR_TIME);
        o_cmd.wr_value  = (r_state == S_RED) && (r_op == OP_WR_VALUE);
        o_cmd.seg_eval  = (r_state == S_SEG);
        o_cmd.div_step  = (r_state == S_DIV) && !i_sts.div_done;
        o_cmd.div_start = (r_state == S_DIV) && i_sts.div_done;
        o_cmd.ch_rd     = (r_state == S_CH_RD);
        o_cmd.ch_mul    = (r_state == S_CH_MUL);
        o_cmd.ch_out    = (r_state == S_CH_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_last_ch <= 1'b0;
            r_op      <= OP_NONE;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= t_op'(i_op);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (i_sts.red_done) begin
                        r_state <= (r_op == OP_QUERY) ? S_SEG_RD : S_IDLE;
                    end
                end
                S_SEG_RD: r_state <= S_SEG;
                S_SEG: begin
                    if (i_sts.seg_hit || i_sts.seg_last) r_state <= S_DIV;
                    else r_state <= S_SEG_RD;
                end
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_CH_RD;
                end
                S_CH_RD: begin
                    r_last_ch <= i_sts.ch_last;
                    r_state   <= S_CH_MUL;
                end
                S_CH_MUL: r_state <= S_CH_OUT;
                S_CH_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_ready) r_state <= r_last_ch ? S_IDLE : S_CH_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_only_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_HOLD)) else $error("result valid outside hold");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.seg_eval, o_cmd.ch_rd, o_cmd.ch_mul, o_cmd.ch_out}))
        else $error("overlapping datapath commands");
`endif
endmodule

[src/cyclic_keyframe_interpolator.sv]
// ============================================================================
// cyclic_keyframe_interpolator
// Cyclic 24-hour keyframe table with linear interpolation of each channel.
// ============================================================================
// Writes: accept, then 0-6 time-reduction steps of one 24 h add or
//   subtract per cycle; the key is written during reduction, no results.
// Query: same reduction, read/evaluate per scanned segment, the divider, then
//   read, multiply, output and hold per channel result, hold waiting on ready.
// One request at a time; results leave through a registered output.
// Reset (synchronous, active low) clears control, sets active_keys to 1; keys kept.
module cyclic_keyframe_interpolator #(
    parameter int MAX_KEYS = 16,
    parameter int CHANNELS = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cki_stream_if.sink                 i_req,
    cki_stream_if.source               o_rsp,
    input  logic                       i_cfg_we,
    input  logic [4:0]                 i_cfg_wdata
);
    import cki_pkg::*;

    logic [CFG_W-1:0] r_active_keys;
    t_cmd cmd;
    t_sts sts;
    t_req req;

    // active key count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active_keys <= CFG_W'(1);
        else if (i_cfg_we) r_active_keys <= i_cfg_wdata;
    end

    assign req = i_req.data;

    cki_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_req.valid), .i_op(req.operation), .o_ready(i_req.ready),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready),
        .o_cmd(cmd), .i_sts(sts));

    cki_datapath #(.MAX_KEYS(MAX_KEYS), .CHANNELS(CHANNELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_cfg(r_active_keys),
        .i_cmd(cmd), .o_sts(sts), .o_rsp(o_rsp.data));
endmodule
